[src/odtw_pkg.sv]
// Shared types and constants of the online warping score follower.
package odtw_pkg;

   localparam int FUNC_W   = 2;
   localparam int NOTE_W   = 8;
   localparam int ENTRY_W  = 10;
   localparam int POS_W    = 10;
   localparam int REPORT_W = 11;
   localparam int COST_W   = 32;
   localparam int LEN_W    = 11;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_RESET  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_STEP   = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   // Register index, taken from the word address of the configuration port.
   localparam logic REG_SCORE_LENGTH = 1'b0;

   localparam logic [LEN_W-1:0] SCORE_LENGTH_RESET = 11'd1;

   typedef struct packed {
      logic capture;   // latch the accepted input word
      logic score_wr;  // write the latched note into the score store
      logic clear_wr;  // clear one cost entry and advance the sweep
      logic step_rd;   // read one score and cost entry for the row update
      logic res_load;  // move the result into the output register
   } odtw_cmd_type;

   typedef struct packed {
      logic last_full; // sweep counter at the last entry of the store
      logic last_len;  // sweep counter at the last entry of the row in use
      logic pipe_busy; // row update still has entries in flight
      logic out_free;  // output register can take a word this cycle
   } odtw_stat_type;

endpackage

[src/odtw_ctrl.sv]
// Controller state machine that sequences load, clear and row update passes.
module odtw_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [odtw_pkg::FUNC_W-1:0]   req_func,
   input  odtw_pkg::odtw_stat_type       stat,
   output odtw_pkg::odtw_cmd_type        cmd,
   output logic                          req_stall
);

   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_LOAD  = 3'd2;
   localparam logic [2:0] ST_CLEAR = 3'd3;
   localparam logic [2:0] ST_STEP  = 3'd4;
   localparam logic [2:0] ST_DRAIN = 3'd5;
   localparam logic [2:0] ST_FIN   = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.clear_wr = 1'b1;
            if (stat.last_full) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               unique case (req_func)
                  odtw_pkg::FUNC_LOAD:   state_in = ST_LOAD;
                  odtw_pkg::FUNC_RESET:  state_in = ST_CLEAR;
                  odtw_pkg::FUNC_STEP:   state_in = ST_STEP;
                  odtw_pkg::FUNC_UNUSED: state_in = ST_FIN;
                  default:               state_in = ST_FIN;
               endcase
            end
         end
         ST_LOAD: begin
            cmd.score_wr = 1'b1;
            state_in     = ST_FIN;
         end
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (stat.last_full) begin
               state_in = ST_FIN;
            end
         end
         ST_STEP: begin
            cmd.step_rd = 1'b1;
            if (stat.last_len) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!stat.pipe_busy) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.res_load = stat.out_free;
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

[src/odtw_datapath.sv]
// Datapath: score and cost memories, row update pipeline and result register.
module odtw_datapath #(
   parameter int MAX_NOTES = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  odtw_pkg::odtw_cmd_type          cmd,
   output odtw_pkg::odtw_stat_type         stat,
   input  logic [odtw_pkg::FUNC_W-1:0]     req_func,
   input  logic [odtw_pkg::NOTE_W-1:0]     req_note,
   input  logic [odtw_pkg::ENTRY_W-1:0]    req_entry_index,
   input  logic [odtw_pkg::LEN_W-1:0]      score_length,
   input  logic                            rsp_stall,
   output logic                            rsp_valid,
   output logic [odtw_pkg::POS_W-1:0]      rsp_position,
   output logic                            rsp_report_valid,
   output logic [odtw_pkg::REPORT_W-1:0]   rsp_report_value,
   output logic [odtw_pkg::COST_W-1:0]     rsp_min_cost
);

   localparam int AW = $clog2(MAX_NOTES);
   localparam int CW = $clog2(MAX_NOTES + 1);
   localparam int LW = (CW > odtw_pkg::LEN_W) ? CW : odtw_pkg::LEN_W;
   localparam int NW = odtw_pkg::NOTE_W;
   localparam int KW = odtw_pkg::COST_W;

   // Latched input word.
   logic [odtw_pkg::FUNC_W-1:0]  func_ff;
   logic [NW-1:0]                note_ff;
   logic [odtw_pkg::ENTRY_W-1:0] entry_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= req_func;
         note_ff  <= req_note;
         entry_ff <= req_entry_index;
      end
   end

   // Effective row length, clamped to one entry at least and the store depth at most.
   logic [LW-1:0] len_raw;
   logic [LW-1:0] len_clamp;
   logic [CW-1:0] len_eff;

   always_comb begin
      len_raw = LW'(score_length);
      if (len_raw == '0) begin
         len_clamp = LW'(1);
      end else if (len_raw > LW'(MAX_NOTES)) begin
         len_clamp = LW'(MAX_NOTES);
      end else begin
         len_clamp = len_raw;
      end
      len_eff = CW'(len_clamp);
   end

   // Sweep counter shared by the clearing pass and the row update.
   logic [AW-1:0] cnt_ff;
   logic [AW-1:0] cnt_in;
   logic [CW-1:0] cnt_ext;
   logic          last_full;
   logic          last_len;

   assign cnt_ext   = CW'(cnt_ff);
   assign last_full = (cnt_ext == CW'(MAX_NOTES - 1));
   assign last_len  = (cnt_ext == (len_eff - CW'(1)));

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.clear_wr) begin
         cnt_in = last_full ? '0 : cnt_ff + AW'(1);
      end else if (cmd.step_rd) begin
         cnt_in = last_len ? '0 : cnt_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Score store.
   logic [NW-1:0] score_mem [MAX_NOTES];
   logic [NW-1:0] score_q;
   logic          load_ok;

   assign load_ok = ({22'd0, entry_ff} < 32'(MAX_NOTES));

   always_ff @(posedge clock) begin
      if (cmd.score_wr && load_ok) begin
         score_mem[AW'(entry_ff)] <= note_ff;
      end
      if (cmd.step_rd) begin
         score_q <= score_mem[cnt_ff];
      end
   end

   // Stage one: accumulated cost of one entry from the freshly read words.
   logic          v1_ff;
   logic [AW-1:0] idx1_ff;
   logic [KW-1:0] old_q;
   logic [KW-1:0] cur_ff;
   logic [KW-1:0] oldprev_ff;
   logic [NW-1:0] note_gap;
   logic [KW-1:0] mn;
   logic [KW:0]   sum;
   logic [KW-1:0] new_cost;

   always_comb begin
      note_gap = (note_ff >= score_q) ? (note_ff - score_q) : (score_q - note_ff);
      if (idx1_ff == '0) begin
         mn = old_q;
      end else begin
         mn = (cur_ff < old_q) ? cur_ff : old_q;
         mn = (oldprev_ff < mn) ? oldprev_ff : mn;
      end
      sum      = {1'b0, mn} + (KW + 1)'(note_gap);
      new_cost = sum[KW] ? '1 : sum[KW-1:0];
   end

   // Cost store: one write port shared by the clearing pass and the row update.
   logic [KW-1:0] cost_mem [MAX_NOTES];
   logic          cost_we;
   logic [AW-1:0] cost_wa;
   logic [KW-1:0] cost_wd;

   assign cost_we = cmd.clear_wr || v1_ff;
   assign cost_wa = cmd.clear_wr ? cnt_ff : idx1_ff;
   assign cost_wd = cmd.clear_wr ? '0 : new_cost;

   always_ff @(posedge clock) begin
      if (cost_we) begin
         cost_mem[cost_wa] <= cost_wd;
      end
      if (cmd.step_rd) begin
         old_q <= cost_mem[cnt_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.step_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step_rd) begin
         idx1_ff <= cnt_ff;
      end
      if (v1_ff) begin
         cur_ff     <= new_cost;
         oldprev_ff <= old_q;
      end
   end

   // Stage two: running minimum, first index wins on a tie.
   logic          v2_ff;
   logic [AW-1:0] idx2_ff;
   logic [KW-1:0] new2_ff;
   logic [KW-1:0] best_ff;
   logic [AW-1:0] pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (v1_ff) begin
         idx2_ff <= idx1_ff;
         new2_ff <= new_cost;
      end
      if (v2_ff && ((idx2_ff == '0) || (new2_ff < best_ff))) begin
         best_ff <= new2_ff;
         pos_ff  <= idx2_ff;
      end
   end

   // Last reported position.
   logic          last_valid_ff;
   logic [AW-1:0] last_pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_valid_ff <= 1'b0;
         last_pos_ff   <= '0;
      end else if (cmd.res_load) begin
         if (func_ff == odtw_pkg::FUNC_RESET) begin
            last_valid_ff <= 1'b0;
            last_pos_ff   <= '0;
         end else if (func_ff == odtw_pkg::FUNC_STEP) begin
            last_valid_ff <= 1'b1;
            last_pos_ff   <= pos_ff;
         end
      end
   end

   // Result word.
   logic [odtw_pkg::POS_W-1:0]    res_pos;
   logic                          res_rv;
   logic [odtw_pkg::REPORT_W-1:0] res_val;
   logic [KW-1:0]                 res_cost;
   logic [AW:0]                   pos_plus;

   assign pos_plus = {1'b0, pos_ff} + (AW + 1)'(1);

   always_comb begin
      res_pos  = '0;
      res_rv   = 1'b0;
      res_val  = '0;
      res_cost = '0;
      unique case (func_ff)
         odtw_pkg::FUNC_RESET: begin
            res_rv = 1'b1;
         end
         odtw_pkg::FUNC_STEP: begin
            res_pos  = odtw_pkg::POS_W'(pos_ff);
            res_cost = best_ff;
            if (!last_valid_ff || (pos_ff != last_pos_ff)) begin
               res_rv  = 1'b1;
               res_val = odtw_pkg::REPORT_W'(pos_plus);
            end
         end
         odtw_pkg::FUNC_LOAD, odtw_pkg::FUNC_UNUSED: begin
            res_rv = 1'b0;
         end
         default: begin
            res_rv = 1'b0;
         end
      endcase
   end

   // Output register.
   logic rsp_valid_ff;
   logic rsp_valid_in;

   assign rsp_valid_in = cmd.res_load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         rsp_position     <= res_pos;
         rsp_report_valid <= res_rv;
         rsp_report_value <= res_val;
         rsp_min_cost     <= res_cost;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   assign stat.last_full = last_full;
   assign stat.last_len  = last_len;
   assign stat.pipe_busy = v1_ff || v2_ff;
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;

endmodule

[src/online_dtw_score_position.sv]
// Top level of the online warping score follower: register port and the two halves.
//
// Each word on the request port is one command: load a score note, reset the warping
// row, or process a detected note; every word yields exactly one response word. A note
// step walks the first score_length entries of the cost row (score_length clamped to
// 1..MAX_NOTES) one entry per cycle through the read port and the write port of the
// cost memory. A row reset clears the whole cost memory one entry per cycle. After
// reset the block runs the same clearing pass and holds req_stall high meanwhile;
// register writes are taken at any time. The response sits in an output register, so
// a new command is taken while it waits.
module online_dtw_score_position #(
   parameter int MAX_NOTES = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [odtw_pkg::FUNC_W-1:0]     req_func,
   input  logic [odtw_pkg::NOTE_W-1:0]     req_note,
   input  logic [odtw_pkg::ENTRY_W-1:0]    req_entry_index,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [odtw_pkg::POS_W-1:0]      rsp_position,
   output logic                            rsp_report_valid,
   output logic [odtw_pkg::REPORT_W-1:0]   rsp_report_value,
   output logic [odtw_pkg::COST_W-1:0]     rsp_min_cost,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [odtw_pkg::CSR_AW-1:0]     csr_paddr,
   input  logic [odtw_pkg::CSR_DW-1:0]     csr_pwdata,
   output logic [odtw_pkg::CSR_DW-1:0]     csr_prdata,
   output logic                            csr_pready
);

   logic [odtw_pkg::LEN_W-1:0] score_length_ff;
   logic                       csr_wr;
   logic                       csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == odtw_pkg::REG_SCORE_LENGTH);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         score_length_ff <= odtw_pkg::SCORE_LENGTH_RESET;
      end else if (csr_wr) begin
         score_length_ff <= csr_pwdata[odtw_pkg::LEN_W-1:0];
      end
   end

   assign csr_prdata = csr_hit ? odtw_pkg::CSR_DW'(score_length_ff) : '0;

   odtw_pkg::odtw_cmd_type  cmd;
   odtw_pkg::odtw_stat_type stat;

   odtw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .stat      (stat),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   odtw_datapath #(
      .MAX_NOTES (MAX_NOTES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_func         (req_func),
      .req_note         (req_note),
      .req_entry_index  (req_entry_index),
      .score_length     (score_length_ff),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_position     (rsp_position),
      .rsp_report_valid (rsp_report_valid),
      .rsp_report_value (rsp_report_value),
      .rsp_min_cost     (rsp_min_cost)
   );

   // The clearing pass after reset keeps the request side closed.
   a_init_stall: assert property (@(posedge clock) (!reset && $past(reset)) |-> req_stall)
      else $error("request taken during the clearing pass after reset");

   // One word is worked on at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second word taken while one is in work");

   // A nonzero report value only comes with a report.
   a_report_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_report_value != '0)) |-> rsp_report_valid)
      else $error("report value without report flag");

   // Commands and the response register are never loaded in the same cycle.
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.capture, cmd.score_wr, cmd.clear_wr, cmd.step_rd, cmd.res_load}) <= 1)
      else $error("controller issued overlapping commands");

endmodule

[tb/tb_top.sv]
// Self-checking testbench of the online warping score follower against a predictor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_NOTES     = 1024;
   localparam int QUIET_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = MAX_NOTES + 16;

   typedef struct packed {
      logic [odtw_pkg::FUNC_W-1:0]  func;
      logic [odtw_pkg::NOTE_W-1:0]  note;
      logic [odtw_pkg::ENTRY_W-1:0] entry_index;
      logic                         hold;   // wait until every response is back before sending
   } follow_cmd_type;

   typedef struct packed {
      logic [odtw_pkg::POS_W-1:0]    position;
      logic                          report_valid;
      logic [odtw_pkg::REPORT_W-1:0] report_value;
      logic [odtw_pkg::COST_W-1:0]   min_cost;
   } follow_rsp_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [odtw_pkg::FUNC_W-1:0]   req_func = '0;
   logic [odtw_pkg::NOTE_W-1:0]   req_note = '0;
   logic [odtw_pkg::ENTRY_W-1:0]  req_entry_index = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [odtw_pkg::POS_W-1:0]    rsp_position;
   logic                          rsp_report_valid;
   logic [odtw_pkg::REPORT_W-1:0] rsp_report_value;
   logic [odtw_pkg::COST_W-1:0]   rsp_min_cost;
   logic                          csr_psel = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite = 1'b0;
   logic [odtw_pkg::CSR_AW-1:0]   csr_paddr = '0;
   logic [odtw_pkg::CSR_DW-1:0]   csr_pwdata = '0;
   logic [odtw_pkg::CSR_DW-1:0]   csr_prdata;
   logic                          csr_pready;

   // Predictor state, updated in acceptance order.
   logic [odtw_pkg::NOTE_W-1:0] score_mem [MAX_NOTES];
   logic [odtw_pkg::COST_W-1:0] cost_mem [MAX_NOTES];
   logic [odtw_pkg::POS_W-1:0]  last_pos;
   logic                        last_pos_ok;
   logic [odtw_pkg::LEN_W-1:0]  len_reg;

   // Score as the stimulus generator sees it once all queued words have been applied.
   logic [odtw_pkg::NOTE_W-1:0] plan_score [MAX_NOTES];
   bit                          plan_loaded [MAX_NOTES];

   follow_cmd_type pending_words[$];
   follow_rsp_type expected_reports[$];
   follow_rsp_type want;

   int n_accepted = 0;
   int n_checked = 0;
   int fail_count = 0;
   int quiet_cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   online_dtw_score_position #(.MAX_NOTES(MAX_NOTES)) dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned eff_length(input logic [odtw_pkg::LEN_W-1:0] value);
      if (value == '0) return 1;
      if (value > MAX_NOTES) return MAX_NOTES;
      return value;
   endfunction

   function automatic logic [odtw_pkg::COST_W-1:0] pitch_gap(
         input logic [odtw_pkg::NOTE_W-1:0] a, input logic [odtw_pkg::NOTE_W-1:0] b);
      return (a > b) ? odtw_pkg::COST_W'(a - b) : odtw_pkg::COST_W'(b - a);
   endfunction

   function automatic logic [odtw_pkg::COST_W-1:0] cost_add(
         input logic [odtw_pkg::COST_W-1:0] a, input logic [odtw_pkg::COST_W-1:0] b);
      logic [odtw_pkg::COST_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[odtw_pkg::COST_W] ? '1 : sum[odtw_pkg::COST_W-1:0];
   endfunction

   function automatic follow_rsp_type advance_follower(input follow_cmd_type w);
      follow_rsp_type r;
      int unsigned n;
      logic [odtw_pkg::COST_W-1:0] old_prev, old_here, run, best, lowest;
      logic [odtw_pkg::POS_W-1:0] pos;
      r = '0;
      case (w.func)
         odtw_pkg::FUNC_LOAD: score_mem[w.entry_index] = w.note;
         odtw_pkg::FUNC_RESET: begin
            foreach (cost_mem[j]) cost_mem[j] = '0;
            last_pos = '0;
            last_pos_ok = 1'b0;
            r.report_valid = 1'b1;
         end
         odtw_pkg::FUNC_STEP: begin
            n = eff_length(len_reg);
            old_prev = cost_mem[0];
            run = cost_add(pitch_gap(w.note, score_mem[0]), cost_mem[0]);
            cost_mem[0] = run;
            best = run;
            pos = '0;
            for (int j = 1; j < n; j++) begin
               old_here = cost_mem[j];
               lowest = (run < old_here) ? run : old_here;
               if (old_prev < lowest) lowest = old_prev;
               run = cost_add(pitch_gap(w.note, score_mem[j]), lowest);
               cost_mem[j] = run;
               old_prev = old_here;
               // Strict compare keeps the lowest index among equal costs.
               if (run < best) begin
                  best = run;
                  pos = odtw_pkg::POS_W'(j);
               end
            end
            if (!last_pos_ok || pos != last_pos) begin
               r.report_valid = 1'b1;
               r.report_value = odtw_pkg::REPORT_W'(pos) + 1'b1;
            end
            last_pos = pos;
            last_pos_ok = 1'b1;
            r.position = pos;
            r.min_cost = best;
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic check_field(input string field, input logic [odtw_pkg::COST_W-1:0] exp_val,
                              input logic [odtw_pkg::COST_W-1:0] got_val);
      if (exp_val !== got_val) begin
         if (fail_count < 10)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_val, got_val);
         fail_count++;
      end
   endtask

   // Driver: the presented word stays put until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_reports.insert(expected_reports.size(),
                                    advance_follower(pending_words.pop_front()));
            n_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_words.size() != 0 && !(pending_words[0].hold && n_accepted != n_checked)
                && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_func <= pending_words[0].func;
               req_note <= pending_words[0].note;
               req_entry_index <= pending_words[0].entry_index;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: every response word is matched against the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            n_checked <= n_checked + 1;
            if (expected_reports.size() == 0) begin
               if (fail_count < 10) $display("%0t: response word with nothing expected", $time);
               fail_count++;
            end else begin
               want = expected_reports.pop_front();
               check_field("position", want.position, rsp_position);
               check_field("report_valid", want.report_valid, rsp_report_valid);
               check_field("report_value", want.report_value, rsp_report_value);
               check_field("min_cost", want.min_cost, rsp_min_cost);
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_word(input logic [odtw_pkg::FUNC_W-1:0] func,
                             input logic [odtw_pkg::NOTE_W-1:0] note,
                             input logic [odtw_pkg::ENTRY_W-1:0] idx, input bit hold);
      follow_cmd_type w;
      w.func = func;
      w.note = note;
      w.entry_index = idx;
      w.hold = hold;
      pending_words.insert(pending_words.size(), w);
      if (func == odtw_pkg::FUNC_LOAD) begin
         plan_score[idx] = note;
         plan_loaded[idx] = 1'b1;
      end
   endtask

   // Waits until every queued word has been answered, then lets a row clear run out.
   task automatic drain();
      while (pending_words.size() != 0 || n_accepted != n_checked) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_length(input logic [odtw_pkg::LEN_W-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= odtw_pkg::CSR_AW'({odtw_pkg::REG_SCORE_LENGTH, 2'b00});
      csr_pwdata <= {(odtw_pkg::CSR_DW-odtw_pkg::LEN_W)'($urandom()), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      len_reg = value;
      @(negedge clock);
   endtask

   // Mostly a melody that walks through the score, mixed with noise, edits and restarts.
   task automatic play_phase(input logic [odtw_pkg::LEN_W-1:0] value, input int count,
                             input int send_pct, input int recv_pct);
      int n, k, r, tone;
      bit hold;
      drain();
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      write_length(value);
      n = eff_length(value);
      for (int j = 0; j < n; j++)
         if (!plan_loaded[j])
            queue_word(odtw_pkg::FUNC_LOAD, odtw_pkg::NOTE_W'($urandom()),
                       odtw_pkg::ENTRY_W'(j), 1'b0);
      k = 0;
      for (int j = 0; j < count; j++) begin
         r = $urandom_range(99);
         hold = ($urandom_range(99) < 3);
         if (r < 60) begin
            queue_word(odtw_pkg::FUNC_STEP, plan_score[k], odtw_pkg::ENTRY_W'($urandom()), hold);
            if ($urandom_range(9) < 7 && k < n - 1) k++;
            if ($urandom_range(9) == 0 && k < n - 1) k++;
         end else if (r < 70) begin
            queue_word(odtw_pkg::FUNC_STEP, odtw_pkg::NOTE_W'($urandom()),
                       odtw_pkg::ENTRY_W'($urandom()), hold);
         end else if (r < 78) begin
            queue_word(odtw_pkg::FUNC_LOAD, odtw_pkg::NOTE_W'($urandom()),
                       odtw_pkg::ENTRY_W'($urandom()), hold);
         end else if (r < 84) begin
            queue_word(odtw_pkg::FUNC_LOAD, odtw_pkg::NOTE_W'($urandom()),
                       odtw_pkg::ENTRY_W'($urandom_range(n - 1)), hold);
         end else if (r < 90) begin
            queue_word(odtw_pkg::FUNC_RESET, odtw_pkg::NOTE_W'($urandom()),
                       odtw_pkg::ENTRY_W'($urandom()), hold);
            k = 0;
         end else if (r < 93) begin
            queue_word(odtw_pkg::FUNC_UNUSED, odtw_pkg::NOTE_W'($urandom()),
                       odtw_pkg::ENTRY_W'($urandom()), hold);
         end else begin
            tone = int'(plan_score[k]) + int'($urandom_range(6)) - 3;
            if (tone < 0) tone = 0;
            if (tone > 255) tone = 255;
            queue_word(odtw_pkg::FUNC_STEP, odtw_pkg::NOTE_W'(tone),
                       odtw_pkg::ENTRY_W'($urandom()), hold);
         end
      end
   endtask

   initial begin
      for (int j = 0; j < MAX_NOTES; j++) begin
         score_mem[j] = '0;
         cost_mem[j] = '0;
         plan_score[j] = '0;
         plan_loaded[j] = 1'b0;
      end
      last_pos = '0;
      last_pos_ok = 1'b0;
      len_reg = odtw_pkg::SCORE_LENGTH_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed words, first at the reset length of one entry.
      send_idle_pct = 13;
      recv_idle_pct = 48;
      @(negedge clock);
      queue_word(odtw_pkg::FUNC_LOAD, 8'd0, 10'd0, 1'b0);
      queue_word(odtw_pkg::FUNC_STEP, 8'd255, 10'd0, 1'b0);
      queue_word(odtw_pkg::FUNC_STEP, 8'd255, 10'd1023, 1'b0);
      queue_word(odtw_pkg::FUNC_UNUSED, 8'd255, 10'd1023, 1'b0);
      queue_word(odtw_pkg::FUNC_STEP, 8'd0, 10'd0, 1'b0);
      queue_word(odtw_pkg::FUNC_RESET, 8'd0, 10'd0, 1'b0);
      queue_word(odtw_pkg::FUNC_STEP, 8'd0, 10'd0, 1'b0);
      queue_word(odtw_pkg::FUNC_LOAD, 8'd255, 10'd1023, 1'b0);
      drain();
      write_length(11'd4);
      queue_word(odtw_pkg::FUNC_LOAD, 8'd255, 10'd1, 1'b0);
      queue_word(odtw_pkg::FUNC_LOAD, 8'd128, 10'd2, 1'b0);
      queue_word(odtw_pkg::FUNC_LOAD, 8'd1, 10'd3, 1'b0);
      queue_word(odtw_pkg::FUNC_RESET, 8'd255, 10'd512, 1'b0);
      queue_word(odtw_pkg::FUNC_STEP, 8'd0, 10'd0, 1'b0);
      queue_word(odtw_pkg::FUNC_STEP, 8'd255, 10'd0, 1'b0);
      queue_word(odtw_pkg::FUNC_STEP, 8'd128, 10'd0, 1'b0);
      queue_word(odtw_pkg::FUNC_STEP, 8'd1, 10'd0, 1'b0);
      queue_word(odtw_pkg::FUNC_STEP, 8'd1, 10'd0, 1'b0);
      queue_word(odtw_pkg::FUNC_STEP, 8'd255, 10'd0, 1'b1);
      drain();
      // A length of zero behaves as one; the row beyond it keeps its costs.
      write_length(11'd0);
      queue_word(odtw_pkg::FUNC_STEP, 8'd0, 10'd0, 1'b0);
      queue_word(odtw_pkg::FUNC_STEP, 8'd255, 10'd0, 1'b0);
      queue_word(odtw_pkg::FUNC_RESET, 8'd0, 10'd0, 1'b0);

      play_phase(11'd5, 60, 13, 48);
      play_phase(11'd16, 60, 13, 48);
      play_phase(11'd1, 30, 13, 48);
      play_phase(11'd40, 60, 48, 13);
      play_phase(11'd64, 30, 48, 13);
      play_phase(11'd9, 60, 48, 13);
      play_phase(11'd100, 30, 0, 0);
      play_phase(11'd0, 30, 0, 0);
      play_phase(11'd3, 50, 0, 0);
      play_phase(11'd128, 40, 0, 0);
      drain();

      if (fail_count == 0 && expected_reports.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
